>>> src/bfd_pkg.sv
// Package for the basic factor dictionary: sizes, action codes and item types.
// Used by the dictionary, its checker and its testbench; depends on nothing.
package bfd_pkg;

	localparam int MAX_LEN    = 1024;
	localparam int POS_W      = $clog2(MAX_LEN);
	localparam int LEN_W      = POS_W + 1;
	localparam int MAX_LEVELS = POS_W;
	localparam int LIDX_W     = $clog2(MAX_LEVELS + 1);
	localparam int RANK_DEPTH = MAX_LEVELS * MAX_LEN;
	localparam int BKT_DEPTH  = MAX_LEN + 2;
	localparam int SYM_W      = 8;
	localparam int NUM_SYM    = 1 << SYM_W;
	localparam int VAL_W      = 11;
	localparam int LVL_W      = 4;

	localparam logic [SYM_W-1:0] SYM_BIAS = 8'h80;

	typedef enum logic [1:0] {
		ACT_LOAD = 2'd0,
		ACT_ID   = 2'd1,
		ACT_SUCC = 2'd2,
		ACT_PRED = 2'd3
	} action_t;

	typedef struct packed {
		action_t                   action;
		logic signed [SYM_W-1:0]   symbol;
		logic                      last;
		logic        [POS_W-1:0]   position;
		logic        [LEN_W-1:0]   factor_length;
		logic        [POS_W-1:0]   factor_id;
	} req_t;

	typedef struct packed {
		logic signed [VAL_W-1:0]   value;
		logic        [LVL_W-1:0]   levels;
		logic                      error;
	} rsp_t;

endpackage

>>> src/basic_factor_dictionary.sv
// Dictionary of basic factors: text store, rank tables built by prefix doubling, queries.
// Depends on bfd_pkg and bfd_ram.
//
// Usage: items enter on req (req_valid / req_stall), results leave on rsp
// (rsp_valid / rsp_stall). A load item writes one text symbol and gives no result,
// unless its last mark is set: then the rank tables are built and one result
// reports the number of levels. A load after a build starts a new text.
// Id, successor and predecessor queries give one result each; a bad query
// (before a build, position past the text, level not built) returns -1 with error.
// A build maps the symbols and ranks the text for level 0, then runs two counting
// sorts and a ranking walk for each further level; all table traffic goes through
// one read port per memory, so every step of the counting sorts is a read, a wait
// and a write. A successor or predecessor scan reads one position at a time.
// One item is worked on at a time.
// The result sits in an output register, so a stalled receiver holds it there
// while the next item is already accepted; req_stall is high while work is in flight.
// Reset clears the control state; the memories need no clearing.
module basic_factor_dictionary (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  bfd_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output bfd_pkg::rsp_t rsp
);

	typedef enum logic [4:0] {
		S_IDLE, S_MAP, S_R0_RT, S_R0_WT, S_R0_WB, S_LVL_CHK, S_CLR,
		S_CNT_RK, S_CNT_WK, S_CNT_WB, S_PFX_RD, S_PFX_WB,
		S_PL_A, S_PL_B, S_PL_C, S_PL_D,
		S_NR_A, S_NR_B, S_NR_C, S_NR_D,
		S_SCAN_RD, S_SCAN_CMP, S_DONE
	} state_t;

	localparam int POS_W  = bfd_pkg::POS_W;
	localparam int LEN_W  = bfd_pkg::LEN_W;
	localparam int LIDX_W = bfd_pkg::LIDX_W;
	localparam int RK_AW  = $clog2(bfd_pkg::RANK_DEPTH);

	state_t                       state_q;
	logic [LEN_W-1:0]             len_q;
	logic [bfd_pkg::LVL_W-1:0]    lvl_cnt_q;
	logic                         built_q;
	logic [bfd_pkg::NUM_SYM-1:0]  present_q;
	logic [LIDX_W-1:0]            lev_q;
	logic [POS_W-1:0]             p_q;
	logic [LEN_W-1:0]             cnt_q;
	logic [LEN_W-1:0]             idx_q;
	logic [LEN_W-1:0]             acc_q;
	logic [LEN_W-1:0]             key_q;
	logic [POS_W-1:0]             sel_i_q;
	logic [POS_W-1:0]             cur_q;
	logic [POS_W-1:0]             a_q;
	logic [POS_W-1:0]             pa_q;
	logic [LEN_W-1:0]             pb_q;
	logic                         pass_q;
	logic [LIDX_W-1:0]            qlev_q;
	logic [POS_W-1:0]             fid_q;
	bfd_pkg::action_t             act_q;
	logic [bfd_pkg::VAL_W-1:0]    res_val_q;
	logic                         res_err_q;
	logic                         rsp_valid_q;
	bfd_pkg::rsp_t                rsp_q;

	// memory ports
	logic                         tx_we;
	logic [POS_W-1:0]             tx_waddr, tx_raddr;
	logic [bfd_pkg::SYM_W-1:0]    tx_wdata, tx_rdata;
	logic                         rk_we;
	logic [RK_AW-1:0]             rk_waddr, rk_raddr;
	logic [POS_W-1:0]             rk_wdata, rk_rdata;
	logic                         bk_we;
	logic [LEN_W-1:0]             bk_waddr, bk_raddr, bk_wdata, bk_rdata;
	logic                         os_we, of_we;
	logic [POS_W-1:0]             os_waddr, os_raddr, os_wdata, os_rdata;
	logic [POS_W-1:0]             of_waddr, of_raddr, of_wdata, of_rdata;

	// derived values
	logic [LEN_W-1:0]             n_m1;
	logic [LEN_W-1:0]             ip_idx, ip_sel;
	logic [LEN_W-1:0]             rk_ext;
	logic [LEN_W-1:0]             key_cnt, key_pl, b_val;
	logic [POS_W-1:0]             cur_n;
	logic [LEN_W-1:0]             len_eff;
	logic [bfd_pkg::SYM_W-1:0]    sym_idx;
	logic [bfd_pkg::NUM_SYM-1:0]  present_nx;
	logic [LIDX_W-1:0]            q_lev;
	logic                         q_err;

	assign n_m1    = len_q - LEN_W'(1);
	assign ip_idx  = {1'b0, idx_q[POS_W-1:0]} + {1'b0, p_q};
	assign ip_sel  = {1'b0, sel_i_q} + {1'b0, p_q};
	assign rk_ext  = {1'b0, rk_rdata};
	assign key_cnt = (pass_q || ip_idx < len_q) ? rk_ext : cnt_q;
	assign key_pl  = (pass_q || ip_sel < len_q) ? rk_ext : cnt_q;
	assign b_val   = (ip_sel < len_q) ? rk_ext : cnt_q;
	assign cur_n   = (idx_q == '0) ? '0 :
		((a_q != pa_q || b_val != pb_q) ? cur_q + POS_W'(1) : cur_q);
	assign len_eff = built_q ? '0 : len_q;
	assign sym_idx = req.symbol ^ bfd_pkg::SYM_BIAS;

	// symbol set after a load: restart it on a new text, mark a stored symbol
	always_comb begin
		present_nx = built_q ? '0 : present_q;
		if (len_eff < LEN_W'(bfd_pkg::MAX_LEN)) begin
			present_nx[sym_idx] = 1'b1;
		end
	end

	// level of a query: floor log2 of the factor length
	always_comb begin
		q_lev = '0;
		for (int k = 0; k < LEN_W; k++) begin
			if (req.factor_length[k]) begin
				q_lev = LIDX_W'(k);
			end
		end
	end

	assign q_err = !built_q || {1'b0, req.position} >= len_q ||
		req.factor_length == '0 || bfd_pkg::LVL_W'(q_lev) >= lvl_cnt_q;

	// drive memory ports from the sequencer state
	always_comb begin
		tx_we    = 1'b0;
		tx_waddr = len_eff[POS_W-1:0];
		tx_wdata = req.symbol;
		tx_raddr = idx_q[POS_W-1:0];
		rk_we    = 1'b0;
		rk_waddr = {lev_q, idx_q[POS_W-1:0]};
		rk_wdata = bk_rdata[POS_W-1:0];
		rk_raddr = {lev_q, idx_q[POS_W-1:0]};
		bk_we    = 1'b0;
		bk_waddr = idx_q;
		bk_wdata = '0;
		bk_raddr = idx_q;
		os_we    = 1'b0;
		os_waddr = bk_rdata[POS_W-1:0];
		os_wdata = sel_i_q;
		os_raddr = idx_q[POS_W-1:0];
		of_we    = 1'b0;
		of_waddr = bk_rdata[POS_W-1:0];
		of_wdata = sel_i_q;
		of_raddr = idx_q[POS_W-1:0];
		case (state_q)
			S_IDLE: begin
				tx_we = req_valid && req.action == bfd_pkg::ACT_LOAD &&
					len_eff < LEN_W'(bfd_pkg::MAX_LEN);
			end
			S_MAP: begin
				bk_we    = 1'b1;
				bk_wdata = acc_q;
			end
			S_R0_WT: begin
				bk_raddr = {{(LEN_W-bfd_pkg::SYM_W){1'b0}}, tx_rdata ^ bfd_pkg::SYM_BIAS};
			end
			S_R0_WB: begin
				rk_we = 1'b1;
			end
			S_CLR: begin
				bk_we = 1'b1;
			end
			S_CNT_RK: begin
				rk_raddr = {lev_q, pass_q ? idx_q[POS_W-1:0] : ip_idx[POS_W-1:0]};
			end
			S_CNT_WK: begin
				bk_raddr = key_cnt + LEN_W'(1);
			end
			S_CNT_WB: begin
				bk_we    = 1'b1;
				bk_waddr = key_q;
				bk_wdata = bk_rdata + LEN_W'(1);
			end
			S_PFX_WB: begin
				bk_we    = 1'b1;
				bk_wdata = acc_q + bk_rdata;
			end
			S_PL_A: begin
				rk_raddr = {lev_q, ip_idx[POS_W-1:0]};
			end
			S_PL_B: begin
				rk_raddr = {lev_q, os_rdata};
			end
			S_PL_C: begin
				bk_raddr = key_pl;
			end
			S_PL_D: begin
				bk_we    = 1'b1;
				bk_waddr = key_q;
				bk_wdata = bk_rdata + LEN_W'(1);
				os_we    = !pass_q;
				of_we    = pass_q;
			end
			S_NR_B: begin
				rk_raddr = {lev_q, of_rdata};
			end
			S_NR_C: begin
				rk_raddr = {lev_q, ip_sel[POS_W-1:0]};
			end
			S_NR_D: begin
				rk_we    = 1'b1;
				rk_waddr = {lev_q + LIDX_W'(1), sel_i_q};
				rk_wdata = cur_n;
			end
			S_SCAN_RD: begin
				rk_raddr = {qlev_q, idx_q[POS_W-1:0]};
			end
			default: begin
			end
		endcase
	end

	// sequencer, text bookkeeping and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			len_q       <= '0;
			lvl_cnt_q   <= '0;
			built_q     <= 1'b0;
			present_q   <= '0;
			lev_q       <= '0;
			p_q         <= '0;
			cnt_q       <= '0;
			idx_q       <= '0;
			acc_q       <= '0;
			key_q       <= '0;
			sel_i_q     <= '0;
			cur_q       <= '0;
			a_q         <= '0;
			pa_q        <= '0;
			pb_q        <= '0;
			pass_q      <= 1'b0;
			qlev_q      <= '0;
			fid_q       <= '0;
			act_q       <= bfd_pkg::ACT_LOAD;
			res_val_q   <= '0;
			res_err_q   <= 1'b0;
			rsp_valid_q <= 1'b0;
			rsp_q       <= '0;
		end else begin
			// drop the result once taken, unless a new one replaces it
			if (rsp_valid_q && !rsp_stall && state_q != S_DONE) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						if (req.action == bfd_pkg::ACT_LOAD) begin
							if (built_q) begin
								built_q   <= 1'b0;
								lvl_cnt_q <= '0;
							end
							present_q <= present_nx;
							if (len_eff < LEN_W'(bfd_pkg::MAX_LEN)) begin
								len_q <= len_eff + LEN_W'(1);
							end else begin
								len_q <= len_eff;
							end
							if (req.last) begin
								idx_q   <= '0;
								acc_q   <= '0;
								lev_q   <= '0;
								p_q     <= POS_W'(1);
								state_q <= S_MAP;
							end
						end else if (q_err) begin
							res_val_q <= '1;
							res_err_q <= 1'b1;
							state_q   <= S_DONE;
						end else begin
							qlev_q    <= q_lev;
							idx_q     <= {1'b0, req.position};
							fid_q     <= req.factor_id;
							act_q     <= req.action;
							res_err_q <= 1'b0;
							state_q   <= S_SCAN_RD;
						end
					end
				end
				// prefix count of present symbols gives the level-0 map
				S_MAP: begin
					acc_q <= acc_q + LEN_W'(present_q[idx_q[bfd_pkg::SYM_W-1:0]]);
					if (idx_q == LEN_W'(bfd_pkg::NUM_SYM - 1)) begin
						cnt_q   <= acc_q + LEN_W'(present_q[idx_q[bfd_pkg::SYM_W-1:0]]);
						idx_q   <= '0;
						state_q <= S_R0_RT;
					end else begin
						idx_q <= idx_q + LEN_W'(1);
					end
				end
				S_R0_RT: state_q <= S_R0_WT;
				S_R0_WT: state_q <= S_R0_WB;
				S_R0_WB: begin
					if (idx_q == n_m1) begin
						state_q <= S_LVL_CHK;
					end else begin
						idx_q   <= idx_q + LEN_W'(1);
						state_q <= S_R0_RT;
					end
				end
				// add a level while twice the half stays below the length
				S_LVL_CHK: begin
					if ({p_q, 1'b0} < len_q) begin
						idx_q   <= '0;
						pass_q  <= 1'b0;
						state_q <= S_CLR;
					end else begin
						lvl_cnt_q <= bfd_pkg::LVL_W'(lev_q) + bfd_pkg::LVL_W'(1);
						built_q   <= 1'b1;
						res_val_q <= '0;
						res_err_q <= 1'b0;
						state_q   <= S_DONE;
					end
				end
				S_CLR: begin
					if (idx_q == cnt_q + LEN_W'(1)) begin
						idx_q   <= '0;
						state_q <= S_CNT_RK;
					end else begin
						idx_q <= idx_q + LEN_W'(1);
					end
				end
				// bucket histogram of the sort key
				S_CNT_RK: state_q <= S_CNT_WK;
				S_CNT_WK: begin
					key_q   <= key_cnt + LEN_W'(1);
					state_q <= S_CNT_WB;
				end
				S_CNT_WB: begin
					if (idx_q == n_m1) begin
						idx_q   <= '0;
						acc_q   <= '0;
						state_q <= S_PFX_RD;
					end else begin
						idx_q   <= idx_q + LEN_W'(1);
						state_q <= S_CNT_RK;
					end
				end
				// running sum turns counts into bucket starts
				S_PFX_RD: state_q <= S_PFX_WB;
				S_PFX_WB: begin
					acc_q <= acc_q + bk_rdata;
					if (idx_q == cnt_q + LEN_W'(1)) begin
						idx_q   <= '0;
						state_q <= S_PL_A;
					end else begin
						idx_q   <= idx_q + LEN_W'(1);
						state_q <= S_PFX_RD;
					end
				end
				// place each position at its bucket slot
				S_PL_A: begin
					if (!pass_q) begin
						sel_i_q <= idx_q[POS_W-1:0];
						state_q <= S_PL_C;
					end else begin
						state_q <= S_PL_B;
					end
				end
				S_PL_B: begin
					sel_i_q <= os_rdata;
					state_q <= S_PL_C;
				end
				S_PL_C: begin
					key_q   <= key_pl;
					state_q <= S_PL_D;
				end
				S_PL_D: begin
					if (idx_q == n_m1) begin
						idx_q <= '0;
						if (!pass_q) begin
							pass_q  <= 1'b1;
							state_q <= S_CLR;
						end else begin
							state_q <= S_NR_A;
						end
					end else begin
						idx_q   <= idx_q + LEN_W'(1);
						state_q <= S_PL_A;
					end
				end
				// walk sorted order and give dense ranks to distinct pairs
				S_NR_A: state_q <= S_NR_B;
				S_NR_B: begin
					sel_i_q <= of_rdata;
					state_q <= S_NR_C;
				end
				S_NR_C: begin
					a_q     <= rk_rdata;
					state_q <= S_NR_D;
				end
				S_NR_D: begin
					cur_q <= cur_n;
					pa_q  <= a_q;
					pb_q  <= b_val;
					if (idx_q == n_m1) begin
						cnt_q   <= {1'b0, cur_n} + LEN_W'(1);
						lev_q   <= lev_q + LIDX_W'(1);
						p_q     <= {p_q[POS_W-2:0], 1'b0};
						state_q <= S_LVL_CHK;
					end else begin
						idx_q   <= idx_q + LEN_W'(1);
						state_q <= S_NR_A;
					end
				end
				// query: read one rank, then compare or step
				S_SCAN_RD: state_q <= S_SCAN_CMP;
				S_SCAN_CMP: begin
					if (act_q == bfd_pkg::ACT_ID) begin
						res_val_q <= rk_ext;
						state_q   <= S_DONE;
					end else if (rk_rdata == fid_q) begin
						res_val_q <= idx_q;
						state_q   <= S_DONE;
					end else if (act_q == bfd_pkg::ACT_SUCC) begin
						if (idx_q == n_m1) begin
							res_val_q <= '1;
							state_q   <= S_DONE;
						end else begin
							idx_q   <= idx_q + LEN_W'(1);
							state_q <= S_SCAN_RD;
						end
					end else begin
						if (idx_q == '0) begin
							res_val_q <= '1;
							state_q   <= S_DONE;
						end else begin
							idx_q   <= idx_q - LEN_W'(1);
							state_q <= S_SCAN_RD;
						end
					end
				end
				// hand the result to the output register when it is free
				S_DONE: begin
					if (!rsp_valid_q || !rsp_stall) begin
						rsp_q.value  <= res_val_q;
						rsp_q.levels <= lvl_cnt_q;
						rsp_q.error  <= res_err_q;
						rsp_valid_q  <= 1'b1;
						state_q      <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign req_stall = (state_q != S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	bfd_ram #(.WIDTH(bfd_pkg::SYM_W), .DEPTH(bfd_pkg::MAX_LEN)) u_text (
		.clk(clk), .we(tx_we), .waddr(tx_waddr), .wdata(tx_wdata),
		.raddr(tx_raddr), .rdata(tx_rdata)
	);

	bfd_ram #(.WIDTH(POS_W), .DEPTH(bfd_pkg::RANK_DEPTH)) u_rank (
		.clk(clk), .we(rk_we), .waddr(rk_waddr), .wdata(rk_wdata),
		.raddr(rk_raddr), .rdata(rk_rdata)
	);

	bfd_ram #(.WIDTH(LEN_W), .DEPTH(bfd_pkg::BKT_DEPTH)) u_bucket (
		.clk(clk), .we(bk_we), .waddr(bk_waddr), .wdata(bk_wdata),
		.raddr(bk_raddr), .rdata(bk_rdata)
	);

	bfd_ram #(.WIDTH(POS_W), .DEPTH(bfd_pkg::MAX_LEN)) u_order_second (
		.clk(clk), .we(os_we), .waddr(os_waddr), .wdata(os_wdata),
		.raddr(os_raddr), .rdata(os_rdata)
	);

	bfd_ram #(.WIDTH(POS_W), .DEPTH(bfd_pkg::MAX_LEN)) u_order_first (
		.clk(clk), .we(of_we), .waddr(of_waddr), .wdata(of_wdata),
		.raddr(of_raddr), .rdata(of_rdata)
	);

endmodule

>>> src/bfd_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// Standalone; depends on nothing.
module bfd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port, registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> src/bfd_check.sv
// Port checker for the basic factor dictionary, bound to the top level.
// Depends on bfd_pkg and basic_factor_dictionary.
module bfd_check (
	input logic          clk,
	input logic          arst_n,
	input logic          req_valid,
	input logic          req_stall,
	input bfd_pkg::req_t req,
	input logic          rsp_valid,
	input logic          rsp_stall,
	input bfd_pkg::rsp_t rsp
);

	// hold a stalled result
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("stalled result changed");

	// flag errors with a miss value
	a_err_value: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.error |-> rsp.value == '1)
		else $error("error result without -1");

	// bound level count
	a_levels: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp.levels <= bfd_pkg::LVL_W'(bfd_pkg::MAX_LEVELS))
		else $error("level count out of range");

	// a query or a build keeps the input stalled in the next cycle
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall && (req.action != bfd_pkg::ACT_LOAD || req.last)
		|=> req_stall)
		else $error("input taken while an item is in work");

endmodule

bind basic_factor_dictionary bfd_check u_bfd_check (.*);

>>> verif/basic_factor_dictionary_tb.sv
// Self-checking testbench for basic_factor_dictionary: directed table, then random texts
// and queries checked against a behavioral rank-table predictor. Depends on bfd_pkg.
// Covers varied idle/stall mixes, a long receiver hold-off and a 40-symbol text.
module basic_factor_dictionary_tb;
	import bfd_pkg::*;

	localparam int WATCHDOG_LIMIT = 600000;
	localparam int HOLD_CYCLES    = 300;

	typedef struct {
		req_t item;
		bit   typed;
		rsp_t want;
	} row_t;

	logic  clk;
	logic  arst_n;
	logic  req_valid;
	logic  req_stall;
	req_t  req;
	logic  rsp_valid;
	logic  rsp_stall;
	rsp_t  rsp;

	// predictor state
	logic [7:0] text_mem [MAX_LEN];
	bit         sym_seen [NUM_SYM];
	int         rank_tbl [MAX_LEVELS][MAX_LEN];
	int         text_len;
	int         level_cnt;
	bit         tables_built;

	rsp_t       expected_q [$];
	int         errors;
	int         sender_idle_pct;
	int         rcv_stall_pct;
	bit         hold_request;

	basic_factor_dictionary DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp      (rsp)
	);

	// clock and reset
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
	end

	// build rank tables by doubling; dense ranks come from an ordered key map
	function automatic void build_ranks();
		int keys [int];
		int ids;
		int lev;
		int half;
		int second;
		int key;
		int nxt;
		ids = 0;
		for (int s = 0; s < NUM_SYM; s++) begin
			if (sym_seen[s]) begin
				keys[s] = ids;
				ids++;
			end
		end
		for (int i = 0; i < text_len; i++)
			rank_tbl[0][i] = keys[int'(text_mem[i] ^ SYM_BIAS)];
		lev = 0;
		half = 1;
		while (2 * half < text_len && lev + 1 < MAX_LEVELS) begin
			keys.delete();
			for (int i = 0; i < text_len; i++) begin
				second = (i + half < text_len) ? rank_tbl[lev][i + half] : ids;
				keys[rank_tbl[lev][i] * (ids + 1) + second] = 0;
			end
			nxt = 0;
			foreach (keys[k]) begin
				keys[k] = nxt;
				nxt++;
			end
			for (int i = 0; i < text_len; i++) begin
				second = (i + half < text_len) ? rank_tbl[lev][i + half] : ids;
				key = rank_tbl[lev][i] * (ids + 1) + second;
				rank_tbl[lev + 1][i] = keys[key];
			end
			ids = nxt;
			lev++;
			half = half * 2;
		end
		level_cnt = lev + 1;
		tables_built = 1'b1;
	endfunction

	// advance the predictor by one accepted item and queue its result, if any
	function automatic void predict_item(req_t it);
		rsp_t r;
		int lev;
		int t;
		int pos;
		r.value = -11'sd1;
		r.error = 1'b0;
		if (it.action == ACT_LOAD) begin
			if (tables_built) begin
				tables_built = 1'b0;
				text_len = 0;
				level_cnt = 0;
				foreach (sym_seen[s]) sym_seen[s] = 1'b0;
			end
			if (text_len < MAX_LEN) begin
				text_mem[text_len] = it.symbol;
				text_len++;
				sym_seen[int'(it.symbol ^ SYM_BIAS)] = 1'b1;
			end
			if (!it.last) return;
			build_ranks();
			r.value = '0;
			r.levels = LVL_W'(level_cnt);
			expected_q.insert(expected_q.size(), r);
			return;
		end
		lev = 0;
		t = it.factor_length;
		while (t > 1) begin
			t = t >> 1;
			lev++;
		end
		pos = it.position;
		if (!tables_built || pos >= text_len || it.factor_length == 0 || lev >= level_cnt) begin
			r.error = 1'b1;
		end else if (it.action == ACT_ID) begin
			r.value = VAL_W'(rank_tbl[lev][pos]);
		end else if (it.action == ACT_SUCC) begin
			for (int i = pos; i < text_len; i++) begin
				if (rank_tbl[lev][i] == it.factor_id) begin
					r.value = VAL_W'(i);
					break;
				end
			end
		end else begin
			for (int i = pos; i >= 0; i--) begin
				if (rank_tbl[lev][i] == it.factor_id) begin
					r.value = VAL_W'(i);
					break;
				end
			end
		end
		r.levels = LVL_W'(level_cnt);
		expected_q.insert(expected_q.size(), r);
	endfunction

	// offer one item at the falling edge, hold it until accepted
	task automatic send_item(req_t it);
		@(negedge clk);
		while ($urandom_range(99) < sender_idle_pct) begin
			req_valid = 1'b0;
			@(negedge clk);
		end
		req_valid = 1'b1;
		req = it;
		do @(posedge clk); while (!(req_valid && !req_stall));
		predict_item(it);
	endtask

	function automatic req_t make_item(action_t act, int sym, bit last, int pos, int flen,
			int fid);
		req_t it;
		it.action = act;
		it.symbol = SYM_W'(sym);
		it.last = last;
		it.position = POS_W'(pos);
		it.factor_length = LEN_W'(flen);
		it.factor_id = POS_W'(fid);
		return it;
	endfunction

	// random load item with noise in the ignored fields
	task automatic send_text(int len, int alpha, int base);
		for (int i = 0; i < len; i++)
			send_item(make_item(ACT_LOAD, base + $urandom_range(alpha - 1), i == len - 1,
				$urandom_range(1023), $urandom_range(2047), $urandom_range(1023)));
	endtask

	// mostly well-formed queries against the current text, some noise
	task automatic send_queries(int cnt);
		int lev;
		int pos;
		int flen;
		int fid;
		for (int q = 0; q < cnt; q++) begin
			lev = $urandom_range(level_cnt - 1);
			pos = $urandom_range(text_len - 1);
			flen = (1 << lev) + $urandom_range((1 << lev) - 1);
			fid = rank_tbl[lev][$urandom_range(text_len - 1)];
			if ($urandom_range(9) == 0) pos = $urandom_range(1023);
			if ($urandom_range(9) == 0) flen = $urandom_range(2047);
			if ($urandom_range(7) == 0) fid = $urandom_range(1023);
			send_item(make_item(action_t'($urandom_range(3, 1)), $urandom_range(255),
				$urandom_range(1), pos, flen, fid));
		end
	endtask

	// receiver: stall at random or hold off on request, check accepted results
	initial begin
		rsp_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_request) begin
				rsp_stall = 1'b1;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_request = 1'b0;
			end
			rsp_stall = ($urandom_range(99) < rcv_stall_pct);
		end
	end

	always @(posedge clk) begin
		rsp_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (expected_q.size() == 0) begin
				$display("%0t: unexpected result value=%0d levels=%0d error=%0b", $time,
					rsp.value, rsp.levels, rsp.error);
				errors++;
			end else begin
				want = expected_q.pop_front();
				if (rsp.value !== want.value) begin
					$display("%0t: value expected %0d actual %0d", $time, want.value,
						rsp.value);
					errors++;
				end
				if (rsp.levels !== want.levels) begin
					$display("%0t: levels expected %0d actual %0d", $time, want.levels,
						rsp.levels);
					errors++;
				end
				if (rsp.error !== want.error) begin
					$display("%0t: error expected %0b actual %0b", $time, want.error,
						rsp.error);
					errors++;
				end
			end
		end
	end

	// watchdog: count cycles with no item moving on either side
	initial begin
		int quiet;
		quiet = 0;
		forever begin
			@(posedge clk);
			if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
				quiet = 0;
			else
				quiet++;
			if (quiet >= WATCHDOG_LIMIT) begin
				$display("CHECKS FAILED");
				$finish;
			end
		end
	end

	// stimulus
	initial begin
		row_t rows [$];
		row_t rw;
		rsp_t err_l0;
		rsp_t err_l2;
		rsp_t err_l1;
		int len;
		int alpha;
		req_valid = 1'b0;
		req = '0;
		errors = 0;
		sender_idle_pct = 0;
		rcv_stall_pct = 0;
		hold_request = 1'b0;
		text_len = 0;
		level_cnt = 0;
		tables_built = 1'b0;
		foreach (sym_seen[s]) sym_seen[s] = 1'b0;
		err_l0 = '{value: -11'sd1, levels: 4'd0, error: 1'b1};
		err_l2 = '{value: -11'sd1, levels: 4'd2, error: 1'b1};
		err_l1 = '{value: -11'sd1, levels: 4'd1, error: 1'b1};

		// directed table: queries before build, a 4-symbol text, bad queries, reload
		rows.insert(rows.size(), '{make_item(ACT_ID, 0, 0, 0, 1, 0), 1, err_l0});
		rows.insert(rows.size(), '{make_item(ACT_SUCC, 0, 0, 0, 1, 0), 1, err_l0});
		rows.insert(rows.size(), '{make_item(ACT_PRED, 0, 0, 0, 1, 0), 1, err_l0});
		rows.insert(rows.size(), '{make_item(ACT_LOAD, -128, 0, 0, 0, 0), 0, '0});
		rows.insert(rows.size(), '{make_item(ACT_LOAD, 127, 0, 0, 0, 0), 0, '0});
		rows.insert(rows.size(), '{make_item(ACT_LOAD, 0, 0, 0, 0, 0), 0, '0});
		rows.insert(rows.size(), '{make_item(ACT_LOAD, 127, 1, 0, 0, 0), 1,
			'{value: 11'sd0, levels: 4'd2, error: 1'b0}});
		rows.insert(rows.size(), '{make_item(ACT_ID, 0, 0, 0, 1, 0), 1,
			'{value: 11'sd0, levels: 4'd2, error: 1'b0}});
		rows.insert(rows.size(), '{make_item(ACT_ID, 0, 0, 1, 1, 0), 1,
			'{value: 11'sd2, levels: 4'd2, error: 1'b0}});
		rows.insert(rows.size(), '{make_item(ACT_ID, 0, 0, 3, 2, 0), 0, '0});
		rows.insert(rows.size(), '{make_item(ACT_ID, 0, 0, 4, 1, 0), 1, err_l2});
		rows.insert(rows.size(), '{make_item(ACT_ID, 0, 0, 0, 0, 0), 1, err_l2});
		rows.insert(rows.size(), '{make_item(ACT_ID, 0, 0, 0, 4, 0), 1, err_l2});
		rows.insert(rows.size(), '{make_item(ACT_ID, 0, 0, 0, 2047, 0), 1, err_l2});
		rows.insert(rows.size(), '{make_item(ACT_SUCC, 0, 0, 0, 1, 2), 1,
			'{value: 11'sd1, levels: 4'd2, error: 1'b0}});
		rows.insert(rows.size(), '{make_item(ACT_SUCC, 0, 0, 2, 1, 1023), 1,
			'{value: -11'sd1, levels: 4'd2, error: 1'b0}});
		rows.insert(rows.size(), '{make_item(ACT_PRED, 0, 0, 3, 1, 0), 1,
			'{value: 11'sd0, levels: 4'd2, error: 1'b0}});
		rows.insert(rows.size(), '{make_item(ACT_PRED, 0, 0, 1023, 1, 0), 1, err_l2});
		rows.insert(rows.size(), '{make_item(ACT_SUCC, 0, 0, 1, 3, 1), 0, '0});
		rows.insert(rows.size(), '{make_item(ACT_PRED, 0, 0, 3, 2, 0), 0, '0});
		rows.insert(rows.size(), '{make_item(ACT_LOAD, 5, 1, 0, 0, 0), 1,
			'{value: 11'sd0, levels: 4'd1, error: 1'b0}});
		rows.insert(rows.size(), '{make_item(ACT_ID, 0, 0, 0, 1, 0), 1,
			'{value: 11'sd0, levels: 4'd1, error: 1'b0}});
		rows.insert(rows.size(), '{make_item(ACT_ID, 0, 0, 0, 2, 0), 1, err_l1});

		@(posedge arst_n);
		foreach (rows[k]) begin
			rw = rows[k];
			send_item(rw.item);
			if (rw.typed) expected_q[expected_q.size() - 1] = rw.want;
		end

		// random texts across idle and stall phases
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				1: begin sender_idle_pct = 56; rcv_stall_pct = 0; end
				2: begin sender_idle_pct = 0; rcv_stall_pct = 56; end
				3: begin sender_idle_pct = 33; rcv_stall_pct = 33; end
				default: begin sender_idle_pct = 0; rcv_stall_pct = 0; end
			endcase
			for (int t = 0; t < 3; t++) begin
				len = ($urandom_range(9) == 0) ? $urandom_range(200, 40)
					: $urandom_range(40, 1);
				alpha = ($urandom_range(3) == 0) ? 256 : $urandom_range(6, 1);
				send_text(len, alpha, (alpha == 256) ? -128 : $urandom_range(255) - 128);
				if (phase == 0 && t == 0) hold_request = 1'b1;
				send_queries(12);
			end
		end

		// a 40-symbol text on a small alphabet, then queries on its tables
		sender_idle_pct = 10;
		rcv_stall_pct = 10;
		send_text(40, 4, -2);
		send_queries(10);

		@(negedge clk);
		req_valid = 1'b0;
		while (expected_q.size() != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		if (errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
